### src/cordic_sc_pkg.sv
// Types, constants and helpers for the CORDIC sine/cosine pipeline.
// No dependencies; used by cordic_sine_cosine.
package cordic_sc_pkg;

	localparam int NUM_REGS  = 6;
	localparam int IDX_W     = 3;
	localparam int ATAN_W    = 10;
	localparam int ANGLE_W   = 14;
	localparam int VEC_W     = 16;
	localparam int PROD_W    = 2 * VEC_W;
	localparam int FRAC_BITS = 12;
	localparam int CORR_W    = PROD_W - FRAC_BITS;
	localparam int SUM_W     = CORR_W + 1;
	localparam int OUT_W     = 16;

	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [OUT_W-1:0]  res_t;
	typedef logic [ATAN_W-1:0]        atan_t;

	// 1.0 in 4.12 pre-scaled by the inverse CORDIC gain
	localparam vec_t SEED_X = 16'sh09B7;

	function automatic atan_t arctan_reset(input logic [IDX_W-1:0] idx);
		atan_t r;
		case (idx)
			3'd0:    r = 10'd511;
			3'd1:    r = 10'd302;
			3'd2:    r = 10'd159;
			3'd3:    r = 10'd81;
			3'd4:    r = 10'd41;
			3'd5:    r = 10'd20;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic res_t sat16(input logic signed [SUM_W-1:0] v);
		res_t r;
		if (v > $signed(SUM_W'(32767)))
			r = 16'sh7FFF;
		else if (v < -$signed(SUM_W'(32768)))
			r = 16'sh8000;
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage

### src/cordic_sine_cosine.sv
// Pipelined CORDIC sine/cosine with residual-angle linear correction.
// Depends on cordic_sc_pkg (types, seed constant, arctan resets, saturation).
//
// Usage:
//   Input channel in_valid/in_stall carries one angle word (signed 2.12 turns).
//   Output channel out_valid/out_stall carries sine and cosine (signed 4.12,
//   saturated to 16 bits). Configuration: cfg_we/cfg_index/cfg_data writes one
//   of the six arctan step words; indexes above five are ignored. Write only
//   while no words are in flight.
// Pipeline:
//   One register per rotation step, one for the two correction multiplies,
//   one for the final add and saturation.
//   Throughput is one word per cycle unless stalled; the rotation stages and
//   the multiply stage each take a new word every cycle unless stalled.
// Reset:
//   arst_n clears all valid bits and loads the default arctan words.
// Stall:
//   When a result is held with out_stall high, the whole pipeline freezes and
//   in_stall rises; nothing is dropped or repeated. Empty slots do not block.
module cordic_sine_cosine #(
	parameter int STEPS = 6
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [cordic_sc_pkg::ANGLE_W-1:0] angle,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [cordic_sc_pkg::OUT_W-1:0] sine,
	output logic signed [cordic_sc_pkg::OUT_W-1:0] cosine,
	input  logic                                   cfg_we,
	input  logic [cordic_sc_pkg::IDX_W-1:0]        cfg_index,
	input  logic [cordic_sc_pkg::ATAN_W-1:0]       cfg_data
);

	localparam int VW = cordic_sc_pkg::VEC_W;
	localparam int AW = cordic_sc_pkg::ATAN_W;

	logic [cordic_sc_pkg::NUM_REGS-1:0][AW-1:0] arctan_q;

	logic adv;

	cordic_sc_pkg::vec_t x_in [STEPS+1];
	cordic_sc_pkg::vec_t y_in [STEPS+1];
	cordic_sc_pkg::vec_t z_in [STEPS+1];
	logic [STEPS:0]      v_in;

	cordic_sc_pkg::vec_t x_s [STEPS];
	cordic_sc_pkg::vec_t y_s [STEPS];
	cordic_sc_pkg::vec_t z_s [STEPS];
	logic [STEPS-1:0]    v_s;

	cordic_sc_pkg::vec_t  x_sm, y_sm;
	cordic_sc_pkg::prod_t zy_sm, zx_sm;
	logic                 v_sm;

	logic signed [cordic_sc_pkg::SUM_W-1:0] cos_wide, sin_wide;

	// whole pipe moves unless a finished word is held
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < cordic_sc_pkg::NUM_REGS; k++)
				arctan_q[k] <= cordic_sc_pkg::arctan_reset(cordic_sc_pkg::IDX_W'(k));
		end else if (cfg_we && (cfg_index < cordic_sc_pkg::IDX_W'(cordic_sc_pkg::NUM_REGS))) begin
			arctan_q[cfg_index] <= cfg_data;
		end
	end

	// seed
	assign x_in[0] = cordic_sc_pkg::SEED_X;
	assign y_in[0] = '0;
	assign z_in[0] = VW'(angle);
	assign v_in[0] = in_valid;

	for (genvar k = 0; k < STEPS; k++) begin : g_rot
		cordic_sc_pkg::vec_t dx, dy, da;

		assign dx = y_in[k] >>> k;
		assign dy = x_in[k] >>> k;
		assign da = $signed({{(VW-AW){1'b0}}, arctan_q[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (adv)
				v_s[k] <= v_in[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_in[k][VW-1]) begin
					x_s[k] <= x_in[k] - dx;
					y_s[k] <= y_in[k] + dy;
					z_s[k] <= z_in[k] - da;
				end else begin
					x_s[k] <= x_in[k] + dx;
					y_s[k] <= y_in[k] - dy;
					z_s[k] <= z_in[k] + da;
				end
			end
		end

		assign x_in[k+1] = x_s[k];
		assign y_in[k+1] = y_s[k];
		assign z_in[k+1] = z_s[k];
		assign v_in[k+1] = v_s[k];
	end

	// residual-angle products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sm <= 1'b0;
		else if (adv)
			v_sm <= v_in[STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_sm  <= x_in[STEPS];
			y_sm  <= y_in[STEPS];
			zy_sm <= cordic_sc_pkg::prod_t'(z_in[STEPS]) * cordic_sc_pkg::prod_t'(y_in[STEPS]);
			zx_sm <= cordic_sc_pkg::prod_t'(z_in[STEPS]) * cordic_sc_pkg::prod_t'(x_in[STEPS]);
		end
	end

	// >>> 12 of the product is its upper bits
	assign cos_wide = cordic_sc_pkg::SUM_W'(x_sm)
		- cordic_sc_pkg::SUM_W'($signed(zy_sm[cordic_sc_pkg::PROD_W-1:cordic_sc_pkg::FRAC_BITS]));
	assign sin_wide = cordic_sc_pkg::SUM_W'(y_sm)
		+ cordic_sc_pkg::SUM_W'($signed(zx_sm[cordic_sc_pkg::PROD_W-1:cordic_sc_pkg::FRAC_BITS]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (adv)
			out_valid <= v_sm;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cosine <= cordic_sc_pkg::sat16(cos_wide);
			sine   <= cordic_sc_pkg::sat16(sin_wide);
		end
	end

`ifndef ASSERT_OFF
	a_first_stage_follows_input: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> v_s[0] == $past(in_valid))
		else $error("first stage valid does not follow accepted input");

	a_output_follows_mult: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> out_valid == $past(v_sm))
		else $error("output valid does not follow multiply stage");

	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_s) && $stable(v_sm))
		else $error("pipeline moved while stalled");

	a_cfg_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index >= cordic_sc_pkg::IDX_W'(cordic_sc_pkg::NUM_REGS))
		|=> $stable(arctan_q))
		else $error("write beyond register list changed a step word");
`endif

endmodule
